### rtl/core/fsd_pkg.sv
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared types, constants and tables for the error-diffusion RGB dither.
// ----------------------------------------------------------------------------
package fsd_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int QUANT_LEVELS = 4;
    localparam int NUM_CH       = 3;

    // configuration port
    localparam int IMG_W_W    = 12;
    localparam int BAND_W     = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_ROWS   = 1'b1;

    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST = 12'd640;
    localparam logic [BAND_W-1:0]  BAND_ROWS_RST   = 13'd4096;

    // stream position
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = BAND_W;
    localparam int WC_W  = ((COL_W > IMG_W_W) ? COL_W : IMG_W_W) + 1;
    localparam int BC_W  = ROW_W + 1;

    // diffusion weights in sixteenths
    localparam int W_RIGHT       = 7;
    localparam int W_BELOW_LEFT  = 3;
    localparam int W_BELOW       = 5;
    localparam int W_BELOW_RIGHT = 1;
    localparam int SHARE_SHIFT   = 4;

    typedef logic [7:0] t_qtab [256];

    // quantized output value for every clamped working value
    function automatic t_qtab f_build_qtab();
        t_qtab tab;
        int    lvl;
        for (int v = 0; v < 256; v++) begin
            lvl    = (2 * QUANT_LEVELS * v + 255) / 510;
            tab[v] = 8'(lvl * (255 / QUANT_LEVELS));
        end
        return tab;
    endfunction

    // largest quantization error magnitude over all values
    function automatic int f_err_max();
        int lvl;
        int q;
        int e;
        int m;
        m = 0;
        for (int v = 0; v < 256; v++) begin
            lvl = (2 * QUANT_LEVELS * v + 255) / 510;
            q   = lvl * (255 / QUANT_LEVELS);
            e   = v - q;
            if (e < 0) begin
                e = -e;
            end
            if (e > m) begin
                m = e;
            end
        end
        return m;
    endfunction

    localparam t_qtab QTAB  = f_build_qtab();
    localparam int    E_MAX = f_err_max();
    localparam int    ERR_W = $clog2(E_MAX + 1) + 1;
    localparam int    V_W   = (ERR_W + 2 > 10) ? ERR_W + 2 : 10;
    localparam int    MUL_W = ERR_W + 2;
    localparam int    RAM_W = NUM_CH * ERR_W;

    // output queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef logic signed [ERR_W-1:0] t_err;

    typedef struct packed {
        logic row_last;
        logic band_last;
        logic x_zero;
    } t_s1_ctl;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
    } t_pix_out;

    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] addr;
        logic [RAM_W-1:0] data;
    } t_err_wr;

endpackage

### rtl/core/fsd_ram.sv
// ----------------------------------------------------------------------------
// fsd_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module fsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/core/fsd_lane.sv
// ----------------------------------------------------------------------------
// fsd_lane
// One color channel: error sum, clamp, quantize, split the error into shares.
// ----------------------------------------------------------------------------
module fsd_lane
    import fsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_s1_ctl    i_ctl,
    input  logic [7:0] i_pixel,
    input  t_err       i_below,
    output logic [7:0] o_level,
    output t_err       o_wr_left,
    output t_err       o_wr_here
);

    t_err                    r_right;
    t_err                    r_pend_here;
    t_err                    r_pend_next;

    logic signed [V_W-1:0]   w_sum;
    logic [7:0]              w_val;
    logic [7:0]              w_q;
    logic signed [8:0]       w_diff;
    t_err                    w_err;
    logic                    w_neg;
    logic [ERR_W-1:0]        w_mag;
    logic [MUL_W-1:0]        w_p7;
    logic [MUL_W-1:0]        w_p3;
    logic [MUL_W-1:0]        w_p5;
    logic [MUL_W-1:0]        w_p1;
    t_err                    w_s7;
    t_err                    w_s3;
    t_err                    w_s5;
    t_err                    w_s1;
    t_err                    w_here;

    // share magnitude truncated, then the sign put back
    function automatic t_err f_share(input logic neg, input logic [MUL_W-1:0] prod);
        logic [ERR_W-1:0] mag;
        mag = ERR_W'(prod >> SHARE_SHIFT);
        return neg ? t_err'(ERR_W'(0) - mag) : t_err'(mag);
    endfunction

    always_comb begin
        w_sum = V_W'($signed({1'b0, i_pixel})) + V_W'(r_right) + V_W'(i_below);
        if (w_sum[V_W-1]) begin
            w_val = 8'd0;
        end else if (|w_sum[V_W-2:8]) begin
            w_val = 8'd255;
        end else begin
            w_val = w_sum[7:0];
        end
        w_q    = QTAB[w_val];
        w_diff = $signed({1'b0, w_val}) - $signed({1'b0, w_q});
        w_err  = t_err'(w_diff);
        w_neg  = w_err[ERR_W-1];
        w_mag  = w_neg ? ERR_W'(-w_err) : ERR_W'(w_err);

        w_p7 = MUL_W'(w_mag) * MUL_W'(W_RIGHT);
        w_p3 = MUL_W'(w_mag) * MUL_W'(W_BELOW_LEFT);
        w_p5 = MUL_W'(w_mag) * MUL_W'(W_BELOW);
        w_p1 = MUL_W'(w_mag) * MUL_W'(W_BELOW_RIGHT);

        w_s7 = i_ctl.row_last ? t_err'(0) : f_share(w_neg, w_p7);
        w_s3 = (i_ctl.band_last || i_ctl.x_zero) ? t_err'(0) : f_share(w_neg, w_p3);
        w_s5 = i_ctl.band_last ? t_err'(0) : f_share(w_neg, w_p5);
        w_s1 = (i_ctl.band_last || i_ctl.row_last) ? t_err'(0) : f_share(w_neg, w_p1);

        w_here = t_err'(r_pend_next + w_s5);
    end

    assign o_level   = w_q;
    assign o_wr_left = t_err'(r_pend_here + w_s3);
    assign o_wr_here = w_here;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right     <= '0;
            r_pend_here <= '0;
            r_pend_next <= '0;
        end else if (i_valid) begin
            if (i_ctl.row_last) begin
                r_right     <= '0;
                r_pend_here <= '0;
                r_pend_next <= '0;
            end else begin
                r_right     <= w_s7;
                r_pend_here <= w_here;
                r_pend_next <= w_s1;
            end
        end
    end

endmodule

### rtl/core/fsd_outq.sv
// ----------------------------------------------------------------------------
// fsd_outq
// Merges the lane results into one word and queues words for the receiver.
// ----------------------------------------------------------------------------
module fsd_outq
    import fsd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [7:0]          i_level [NUM_CH],
    input  logic                i_row_end,
    output logic                o_valid,
    input  logic                i_stall,
    output t_pix_out            o_word,
    output logic [OQ_CNT_W-1:0] o_count
);

    t_pix_out            r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0]    r_wr_ptr;
    logic [OQ_AW-1:0]    r_rd_ptr;
    logic [OQ_CNT_W-1:0] r_count;
    logic [OQ_CNT_W-1:0] n_count;
    logic                w_pop;
    t_pix_out            w_word;

    always_comb begin
        w_word.red     = i_level[0];
        w_word.green   = i_level[1];
        w_word.blue    = i_level[2];
        w_word.row_end = i_row_end;
    end

    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign w_pop   = o_valid && !i_stall;

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= w_word;
        end
    end

endmodule

### rtl/core/floyd_steinberg_rgb_dither.sv
// ----------------------------------------------------------------------------
// floyd_steinberg_rgb_dither
// Error-diffusion dither of an RGB raster stream with a line store for errors.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the input channel (i_in_valid / o_in_stall)
// and leave one for one on the output channel (o_out_valid / i_out_stall).
// Each output word carries the three quantized channels and a row_end flag
// on the last pixel of a row.
// An accepted pixel is registered in the lane stage, then queued for output.
// Throughput: one pixel per clock when the input is not stalled, set by the
// loop that carries the right-hand error from pixel to pixel per channel lane.
// Row errors live in a 2048-entry line store read ahead through its
// registered port; writes that have not yet reached the store are forwarded.
// Results wait in a four-word queue; the receiver may stall at will, and the
// input stalls when the queue and the lane stage hold four words.
// After reset the line store is cleared, one entry a cycle, over all 2048
// entries, and the input stalls meanwhile. Configuration writes are taken
// at any time and belong in the idle gaps between images or bands.
// ----------------------------------------------------------------------------
module floyd_steinberg_rgb_dither
    import fsd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input pixels
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_red_in,
    input  logic [7:0]            i_green_in,
    input  logic [7:0]            i_blue_in,
    // output pixels
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [7:0]            o_red_out,
    output logic [7:0]            o_green_out,
    output logic [7:0]            o_blue_out,
    output logic                  o_row_end
);

    logic [IMG_W_W-1:0]  r_image_width;
    logic [BAND_W-1:0]   r_band_rows;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;

    logic                r_clr_busy;
    logic [COL_W-1:0]    r_clr_addr;

    logic                r_s1_valid;
    logic [COL_W-1:0]    r_s1_x;
    t_s1_ctl             r_s1_ctl;
    logic [7:0]          r_s1_pix [NUM_CH];

    t_err_wr             r_pend;
    t_err_wr             r_byp;

    logic                w_in_acc;
    logic                w_row_last;
    logic                w_band_last;
    logic [WC_W-1:0]     w_col_nxt;
    logic [BC_W-1:0]     w_row_nxt;

    logic [RAM_W-1:0]    w_ram_rdata;
    logic                w_ram_we;
    logic [COL_W-1:0]    w_ram_waddr;
    logic [RAM_W-1:0]    w_ram_wdata;
    logic                w_wr_left_valid;
    logic [RAM_W-1:0]    w_wr_left_data;
    logic [RAM_W-1:0]    w_wr_here_data;
    logic [RAM_W-1:0]    w_below_word;

    logic [7:0]          w_level [NUM_CH];
    t_err                w_wr_left [NUM_CH];
    t_err                w_wr_here [NUM_CH];

    t_pix_out            w_out_word;
    logic [OQ_CNT_W-1:0] w_oq_count;
    logic [OQ_CNT_W-1:0] w_occupancy;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= IMAGE_WIDTH_RST;
            r_band_rows   <= BAND_ROWS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH: r_image_width <= i_cfg_data[IMG_W_W-1:0];
                REG_BAND_ROWS:   r_band_rows   <= i_cfg_data[BAND_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- position and input stage ----------------
    assign w_occupancy = w_oq_count + OQ_CNT_W'(r_s1_valid);
    assign o_in_stall  = r_clr_busy || (w_occupancy == OQ_CNT_W'(OQ_DEPTH));
    assign w_in_acc    = i_in_valid && !o_in_stall;

    // a zero width or band register acts as one
    assign w_col_nxt   = WC_W'(r_col) + 1'b1;
    assign w_row_nxt   = BC_W'(r_row) + 1'b1;
    assign w_row_last  = (w_col_nxt >= WC_W'(r_image_width))
                      || (w_col_nxt >= WC_W'(MAX_WIDTH));
    assign w_band_last = (w_row_nxt >= BC_W'(r_band_rows));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_in_acc;
            if (w_in_acc) begin
                if (w_row_last) begin
                    r_col <= '0;
                    r_row <= w_band_last ? '0 : w_row_nxt[ROW_W-1:0];
                end else begin
                    r_col <= w_col_nxt[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_x             <= r_col;
            r_s1_ctl.row_last  <= w_row_last;
            r_s1_ctl.band_last <= w_band_last;
            r_s1_ctl.x_zero    <= (r_col == '0);
            r_s1_pix[0]        <= i_red_in;
            r_s1_pix[1]        <= i_green_in;
            r_s1_pix[2]        <= i_blue_in;
        end
    end

    // ---------------- line store ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == COL_W'(MAX_WIDTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // the row-end write of the current column waits in r_pend for the next cycle;
    // the next pixel is in column zero and has no write of its own
    assign w_wr_left_valid = r_s1_valid && !r_s1_ctl.x_zero;

    always_comb begin
        if (r_clr_busy) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = r_clr_addr;
            w_ram_wdata = '0;
        end else if (w_wr_left_valid) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = r_s1_x - 1'b1;
            w_ram_wdata = w_wr_left_data;
        end else begin
            w_ram_we    = r_pend.valid;
            w_ram_waddr = r_pend.addr;
            w_ram_wdata = r_pend.data;
        end
    end

    fsd_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_col),
        .o_rdata (w_ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_byp  <= '0;
        end else begin
            r_pend.valid <= r_s1_valid && r_s1_ctl.row_last;
            r_pend.addr  <= r_s1_x;
            r_pend.data  <= w_wr_here_data;
            // write landing on the same edge as the read is forwarded
            r_byp.valid  <= !r_clr_busy && w_ram_we;
            r_byp.addr   <= w_ram_waddr;
            r_byp.data   <= w_ram_wdata;
        end
    end

    always_comb begin
        if (r_pend.valid && (r_pend.addr == r_s1_x)) begin
            w_below_word = r_pend.data;
        end else if (r_byp.valid && (r_byp.addr == r_s1_x)) begin
            w_below_word = r_byp.data;
        end else begin
            w_below_word = w_ram_rdata;
        end
    end

    // ---------------- channel lanes ----------------
    for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
        fsd_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (r_s1_valid),
            .i_ctl     (r_s1_ctl),
            .i_pixel   (r_s1_pix[c]),
            .i_below   (t_err'(w_below_word[c*ERR_W +: ERR_W])),
            .o_level   (w_level[c]),
            .o_wr_left (w_wr_left[c]),
            .o_wr_here (w_wr_here[c])
        );
        assign w_wr_left_data[c*ERR_W +: ERR_W] = w_wr_left[c];
        assign w_wr_here_data[c*ERR_W +: ERR_W] = w_wr_here[c];
    end

    // ---------------- merge and output queue ----------------
    fsd_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (r_s1_valid),
        .i_level   (w_level),
        .i_row_end (r_s1_ctl.row_last),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_word    (w_out_word),
        .o_count   (w_oq_count)
    );

    assign o_red_out   = w_out_word.red;
    assign o_green_out = w_out_word.green;
    assign o_blue_out  = w_out_word.blue;
    assign o_row_end   = w_out_word.row_end;

    // ---------------- assertions ----------------
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_wr_left_valid && r_pend.valid))
        else $error("line store write collision");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_occupancy <= OQ_CNT_W'(OQ_DEPTH))
        else $error("output queue overrun");

    a_row_end_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_ctl.row_last) |=>
            (r_pend.valid && (r_pend.addr == $past(r_s1_x))))
        else $error("row end error not queued for the line store");

    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_row_last) |=> (r_col == '0) && r_s1_ctl.row_last)
        else $error("column count did not wrap at row end");

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGB error-diffusion dither.
// ----------------------------------------------------------------------------
// A driver pulls pixels from a queue and offers them on the input channel
// with random gaps; a monitor predicts every accepted pixel with its own
// copy of the diffusion state and checks each output word against the
// oldest prediction while stalling the output at random. Directed pixels
// hit the level thresholds, the extremes and the register corner cases
// (width and band size lowered mid-row, zero and oversized values), then
// random image phases of varied width and band size follow.
// ----------------------------------------------------------------------------
module tb_top
    import fsd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb_word;

    localparam int          RANDOM_ITEMS = 1280;
    localparam logic [7:0]  LEVEL_STEPS [8] = '{8'd31, 8'd32, 8'd95, 8'd96,
                                                 8'd159, 8'd160, 8'd223, 8'd224};

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [7:0]            i_red_in    = '0;
    logic [7:0]            i_green_in  = '0;
    logic [7:0]            i_blue_in   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [7:0]            o_red_out;
    logic [7:0]            o_green_out;
    logic [7:0]            o_blue_out;
    logic                  o_row_end;

    floyd_steinberg_rgb_dither u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_red_in    (i_red_in),
        .i_green_in  (i_green_in),
        .i_blue_in   (i_blue_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_red_out   (o_red_out),
        .o_green_out (o_green_out),
        .o_blue_out  (o_blue_out),
        .o_row_end   (o_row_end)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // stimulus and expectations
    t_rgb_word pixel_queue [$];
    t_pix_out  dither_exp [$];
    int        n_queued   = 0;
    int        n_fail     = 0;
    int        n_accepted = 0;
    bit        tx_gaps_on = 1'b0;
    bit        rx_gaps_on = 1'b0;
    bit        press_go   = 1'b0;
    logic      rx_hold    = 1'b0;

    // predictor state
    logic [IMG_W_W-1:0] cfg_width = IMAGE_WIDTH_RST;
    logic [BAND_W-1:0]  cfg_band  = BAND_ROWS_RST;
    int                 below_err [MAX_WIDTH][NUM_CH];
    int                 right_carry [NUM_CH];
    int                 below_here [NUM_CH];
    int                 below_next [NUM_CH];
    int                 col_pos  = 0;
    int                 band_row = 0;

    // e*w/16 rounded toward zero
    function automatic int diffuse_share(int e, int w);
        if (e < 0) begin
            return -(((-e) * w) / 16);
        end
        return (e * w) / 16;
    endfunction

    function automatic t_pix_out dither_pixel(t_rgb_word px);
        int         w;
        int         b;
        int         x;
        int         v;
        int         lvl;
        int         q;
        int         e;
        int         s1;
        int         s3;
        int         s5;
        int         s7;
        logic       row_last;
        logic       band_last;
        logic [7:0] chan [NUM_CH];
        logic [7:0] quant [NUM_CH];
        t_pix_out   res;
        chan[0] = px.red;
        chan[1] = px.green;
        chan[2] = px.blue;
        w = int'(cfg_width);
        b = int'(cfg_band);
        x = col_pos;
        if (w < 1) begin
            w = 1;
        end
        if (w > MAX_WIDTH) begin
            w = MAX_WIDTH;
        end
        if (b < 1) begin
            b = 1;
        end
        if (x >= MAX_WIDTH) begin
            x = MAX_WIDTH - 1;
        end
        row_last  = (x + 1 >= w);
        band_last = (band_row + 1 >= b);
        for (int c = 0; c < NUM_CH; c++) begin
            v = int'(chan[c]) + right_carry[c] + below_err[x][c];
            if (v < 0) begin
                v = 0;
            end
            if (v > 255) begin
                v = 255;
            end
            lvl = (2 * QUANT_LEVELS * v + 255) / 510;
            q   = lvl * (255 / QUANT_LEVELS);
            e   = v - q;
            s7  = row_last ? 0 : diffuse_share(e, W_RIGHT);
            s3  = (band_last || x == 0) ? 0 : diffuse_share(e, W_BELOW_LEFT);
            s5  = band_last ? 0 : diffuse_share(e, W_BELOW);
            s1  = (band_last || row_last) ? 0 : diffuse_share(e, W_BELOW_RIGHT);
            right_carry[c] = s7;
            if (x > 0) begin
                below_err[x - 1][c] = below_here[c] + s3;
            end
            below_here[c] = below_next[c] + s5;
            below_next[c] = s1;
            if (row_last) begin
                below_err[x][c] = below_here[c];
                below_here[c]   = 0;
                below_next[c]   = 0;
                right_carry[c]  = 0;
            end
            quant[c] = q[7:0];
        end
        res.red     = quant[0];
        res.green   = quant[1];
        res.blue    = quant[2];
        res.row_end = row_last;
        if (row_last) begin
            col_pos  = 0;
            band_row = band_last ? 0 : band_row + 1;
        end else begin
            col_pos = x + 1;
        end
        return res;
    endfunction

    task automatic note_failure(string msg);
        n_fail++;
        if (n_fail <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // driver
    t_rgb_word drv_px;
    int        gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pixel_queue.size() != 0) begin
                drv_px = pixel_queue.pop_front();
                i_red_in   <= drv_px.red;
                i_green_in <= drv_px.green;
                i_blue_in  <= drv_px.blue;
                i_in_valid <= 1'b1;
                if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
                    gap_left = $urandom_range(1, 12);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor
    t_pix_out want;
    int       stall_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                dither_exp.push_back(dither_pixel({i_red_in, i_green_in, i_blue_in}));
                n_accepted++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (dither_exp.size() == 0) begin
                    note_failure("output word with nothing expected");
                end else begin
                    want = dither_exp.pop_front();
                    if (o_red_out !== want.red || o_green_out !== want.green ||
                        o_blue_out !== want.blue || o_row_end !== want.row_end) begin
                        note_failure($sformatf(
                            "expected r=%0d g=%0d b=%0d end=%0b, got r=%0d g=%0d b=%0d end=%0b",
                            want.red, want.green, want.blue, want.row_end,
                            o_red_out, o_green_out, o_blue_out, o_row_end));
                    end
                end
            end
            if (rx_hold) begin
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (rx_gaps_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 11);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // long output hold so the block backs up into its input
    initial begin
        wait (press_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return LEVEL_STEPS[$urandom_range(0, 7)];
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] near_level(logic [7:0] base);
        int v;
        v = int'(base) + int'($urandom_range(0, 4)) - 2;
        if (v < 0) begin
            v = 0;
        end
        if (v > 255) begin
            v = 255;
        end
        return v[7:0];
    endfunction

    task automatic push_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pixel_queue.push_back({r, g, b});
        n_queued++;
    endtask

    // flat areas, ramps and noise
    task automatic queue_pixels(int n);
        t_rgb_word base;
        t_rgb_word px;
        int        style;
        int        stride;
        style  = $urandom_range(0, 3);
        base   = {pick_level(), pick_level(), pick_level()};
        stride = $urandom_range(1, 9);
        for (int i = 0; i < n; i++) begin
            case (style)
                0: px = {base.red + 8'(i * stride), base.green - 8'(i * stride),
                         base.blue + 8'(i)};
                1: px = {near_level(base.red), near_level(base.green),
                         near_level(base.blue)};
                default: px = {pick_level(), pick_level(), pick_level()};
            endcase
            pixel_queue.push_back(px);
        end
        n_queued += n;
    endtask

    // registers change only with nothing in flight
    task automatic start_phase(logic [CFG_DATA_W-1:0] wd, logic [CFG_DATA_W-1:0] bd);
        do @(negedge i_clk);
        while (pixel_queue.size() != 0 || i_in_valid || dither_exp.size() != 0);
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_IMAGE_WIDTH;
        i_cfg_data  <= wd;
        @(posedge i_clk);
        cfg_width = wd[IMG_W_W-1:0];
        i_cfg_index <= REG_BAND_ROWS;
        i_cfg_data  <= bd;
        @(posedge i_clk);
        cfg_band = bd[BAND_W-1:0];
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] wd;
        logic [CFG_DATA_W-1:0] bd;
        int                    ws;
        int                    n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // two full rows of a three-row band, then stop two pixels into the third
        start_phase(13'd5, 13'd3);
        push_rgb(8'd0, 8'd0, 8'd0);
        push_rgb(8'd255, 8'd255, 8'd255);
        push_rgb(8'd31, 8'd32, 8'd95);
        push_rgb(8'd96, 8'd159, 8'd160);
        push_rgb(8'd223, 8'd224, 8'd0);
        push_rgb(8'd255, 8'd0, 8'd255);
        push_rgb(8'd0, 8'd255, 8'd0);
        push_rgb(8'd128, 8'd127, 8'd64);
        push_rgb(8'd1, 8'd254, 8'd200);
        push_rgb(8'd255, 8'd255, 8'd255);
        push_rgb(8'd0, 8'd0, 8'd0);
        push_rgb(8'd170, 8'd85, 8'd42);
        // width and band size below the current position
        start_phase(13'd2, 13'd1);
        push_rgb(8'd255, 8'd255, 8'd255);
        push_rgb(8'd0, 8'd0, 8'd0);
        push_rgb(8'd32, 8'd96, 8'd224);
        push_rgb(8'd31, 8'd95, 8'd223);
        // zero acts as one
        start_phase(13'd0, 13'd0);
        push_rgb(8'd200, 8'd100, 8'd50);
        push_rgb(8'd50, 8'd200, 8'd100);
        push_rgb(8'd100, 8'd50, 8'd200);
        // oversized width saturates at the line store size
        start_phase(13'h1FFF, 13'h1FFF);
        push_rgb(8'd255, 8'd0, 8'd128);
        push_rgb(8'd0, 8'd255, 8'd127);
        push_rgb(8'd64, 8'd191, 8'd255);
        push_rgb(8'd100, 8'd100, 8'd100);

        while (n_queued < RANDOM_ITEMS) begin
            if (!press_go && n_queued >= 500) begin
                start_phase(13'd8, 13'd4);
                tx_gaps_on = 1'b0;
                rx_gaps_on = 1'b1;
                press_go   = 1'b1;
                queue_pixels(200);
            end else begin
                case ($urandom_range(0, 9))
                    0:       wd = '0;
                    1:       wd = CFG_DATA_W'(13'h1000 | $urandom_range(1, 20));
                    2:       wd = CFG_DATA_W'($urandom_range(MAX_WIDTH, 4095));
                    default: wd = CFG_DATA_W'($urandom_range(1, 24));
                endcase
                case ($urandom_range(0, 7))
                    0:       bd = '0;
                    1:       bd = 13'h1FFF;
                    2:       bd = CFG_DATA_W'($urandom_range(4096, 8190));
                    default: bd = CFG_DATA_W'($urandom_range(1, 6));
                endcase
                ws = int'(wd[IMG_W_W-1:0]);
                if (ws < 1) begin
                    ws = 1;
                end
                if (ws > MAX_WIDTH) begin
                    ws = MAX_WIDTH;
                end
                if (ws > 64) begin
                    n = $urandom_range(20, 60);
                end else if ($urandom_range(0, 3) == 0) begin
                    // may stop mid-row, so the next setting can land inside a row
                    n = $urandom_range(1, 3 * ws);
                end else begin
                    n = ws * $urandom_range(1, 6);
                end
                start_phase(wd, bd);
                tx_gaps_on = ($urandom_range(0, 3) != 0);
                rx_gaps_on = ($urandom_range(0, 3) != 0);
                queue_pixels(n);
            end
        end

        // full rate to the end
        start_phase(13'd10, 13'd5);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        queue_pixels(150);

        do @(negedge i_clk);
        while (pixel_queue.size() != 0 || i_in_valid);
        for (int k = 0; k < 2000 && dither_exp.size() != 0; k++) begin
            @(negedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (dither_exp.size() != 0) begin
            note_failure($sformatf("%0d expected words never arrived", dither_exp.size()));
        end
        if (n_fail == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### floyd_steinberg_rgb_dither.f
rtl/core/fsd_pkg.sv
rtl/core/fsd_ram.sv
rtl/core/fsd_lane.sv
rtl/core/fsd_outq.sv
rtl/core/floyd_steinberg_rgb_dither.sv
verif/tb_top.sv
